// ===== src/gss_pkg.sv =====
// Package for the Gauss-Seidel solver: item kind codes, register indexes
// and Q16.16 arithmetic helpers. No dependencies.
package gss_pkg;

   localparam logic [1:0] KIND_LOAD_C = 2'd0;
   localparam logic [1:0] KIND_LOAD_G = 2'd1;
   localparam logic [1:0] KIND_LOAD_X = 2'd2;
   localparam logic [1:0] KIND_SOLVE  = 2'd3;

   localparam logic CSR_TOLERANCE  = 1'b0;
   localparam logic CSR_MAX_SWEEPS = 1'b1;

   localparam logic [30:0] TOL_RESET   = 31'd66;
   localparam logic [15:0] SWEEP_RESET = 16'd1000;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
   } ctl_type;

   // floor shift of an exact Q32.32 product down to Q16.16, sign-extended to 64
   function automatic logic signed [63:0] floor_q16(input logic signed [63:0] p);
      floor_q16 = p >>> 16;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction

endpackage

// ===== src/gss_mem.sv =====
// Simple one-write one-read synchronous memory with registered read data.
// Depends on nothing.
module gss_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic signed [31:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic signed [31:0] rd_data
);
   logic signed [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/gauss_seidel_solver.sv =====
// Gauss-Seidel solver, signed Q16.16. A load item is written when accepted and
// leaves busy low. A solve item keeps busy high through its last result: in each
// sweep, each row issues DIM matrix and vector reads through a single read port
// of each memory, one multiply-accumulate per cycle, drains the read/multiply
// pipeline, adds the offset and writes back; then DIM results, each after its
// own read state. Results cannot be stalled. Depends on gss_pkg and gss_mem.
module gauss_seidel_solver #(
   parameter int DIM = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [2:0]         req_row,
   input  logic [2:0]         req_col,
   input  logic signed [31:0] req_value,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [30:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [2:0]         rsp_index,
   output logic signed [31:0] rsp_solution,
   output logic [15:0]        rsp_sweeps,
   output logic               rsp_converged,
   output logic               rsp_last
);
   localparam int XW = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int CW = 2 * XW;
   localparam int JW = $clog2(DIM + 2);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAC  = 3'd1;
   localparam logic [2:0] ST_ADDG = 3'd2;
   localparam logic [2:0] ST_WB   = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;
   localparam logic [2:0] ST_ERD  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [30:0] tol_ff;
   logic [15:0] cap_ff;
   logic [XW-1:0] i_ff, i_in;
   logic [JW-1:0] j_ff, j_in;
   logic          pv_ff, pv_in;          // product data valid in prod_ff
   logic signed [63:0] prod_ff, acc_ff, acc_in;
   logic signed [31:0] old_ff, old_in;
   logic [31:0]   worst_ff, worst_in;
   logic [15:0]   sw_ff, sw_in;
   logic          met_ff, met_in;

   logic          c_we, x_we, g_we;
   logic [CW-1:0] c_wa, c_ra;
   logic [XW-1:0] x_wa, x_ra, g_wa;
   logic signed [31:0] x_wd, c_rd, x_rd, g_rd;
   logic signed [31:0] nx;
   logic signed [32:0] dlt;
   logic [31:0]   adlt;
   logic          in_rng;
   logic          row_ok;

   logic accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign row_ok = ({5'd0, req_row} < 8'(DIM));
   assign in_rng = row_ok && ({5'd0, req_col} < 8'(DIM));

   gss_mem #(.DEPTH(DIM*DIM), .AW(CW)) u_cmem (
      .clock(clock), .wr_en(c_we), .wr_addr(c_wa), .wr_data(req_value),
      .rd_addr(c_ra), .rd_data(c_rd));
   gss_mem #(.DEPTH(DIM), .AW(XW)) u_gmem (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wa), .wr_data(req_value),
      .rd_addr(i_ff), .rd_data(g_rd));
   gss_mem #(.DEPTH(DIM), .AW(XW)) u_xmem (
      .clock(clock), .wr_en(x_we), .wr_addr(x_wa), .wr_data(x_wd),
      .rd_addr(x_ra), .rd_data(x_rd));

   assign c_we = accept && req_kind == gss_pkg::KIND_LOAD_C && in_rng;
   assign c_wa = CW'(req_row) * CW'(DIM) + CW'(req_col);
   assign g_we = accept && req_kind == gss_pkg::KIND_LOAD_G && row_ok;
   assign g_wa = XW'(req_row);
   assign nx   = gss_pkg::sat32(acc_ff);
   assign dlt  = {nx[31], nx} - {old_ff[31], old_ff};
   assign adlt = dlt[32] ? 32'(-dlt) : dlt[31:0];

   always_comb begin
      x_we = 1'b0;
      x_wa = XW'(req_row);
      x_wd = req_value;
      if (accept && req_kind == gss_pkg::KIND_LOAD_X && row_ok) begin
         x_we = 1'b1;
      end else if (state_ff == ST_WB) begin
         x_we = 1'b1;
         x_wa = i_ff;
         x_wd = nx;
      end
   end

   always_comb begin
      c_ra = CW'(i_ff) * CW'(DIM) + CW'(j_ff[XW-1:0]);
      x_ra = (state_ff == ST_MAC && j_ff < JW'(DIM)) ? j_ff[XW-1:0] : i_ff;
   end

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; pv_in = 1'b0;
      acc_in = acc_ff; old_in = old_ff; worst_in = worst_ff;
      sw_in = sw_ff; met_in = met_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == gss_pkg::KIND_SOLVE) begin
               state_in = ST_MAC; i_in = '0; j_in = '0;
               acc_in = '0; worst_in = '0; sw_in = '0;
            end
         end
         ST_MAC: begin
            // issue read of column j; accumulate the registered product when pv_ff marks it valid
            if (pv_ff) acc_in = acc_ff + gss_pkg::floor_q16(prod_ff);
            if (j_ff < JW'(DIM)) begin
               pv_in = 1'b1;
               j_in = j_ff + 1'b1;
            end else if (!pv_ff) begin
               state_in = ST_ADDG;
            end
            if (j_ff == JW'(DIM)) j_in = j_ff + 1'b1;
         end
         ST_ADDG: begin
            acc_in = acc_ff + 64'(g_rd);
            old_in = x_rd;
            state_in = ST_WB;
         end
         ST_WB: begin
            if (adlt > worst_ff) worst_in = adlt;
            acc_in = '0; j_in = '0;
            if (i_ff == XW'(DIM - 1)) begin
               i_in = '0;
               sw_in = sw_ff + 1'b1;
               met_in = ((adlt > worst_ff) ? adlt : worst_ff) < {1'b0, tol_ff};
               if (((adlt > worst_ff) ? adlt : worst_ff) < {1'b0, tol_ff} ||
                   sw_ff + 1'b1 >= ((cap_ff == 16'd0) ? 16'd1 : cap_ff)) begin
                  state_in = ST_ERD;
               end else begin
                  worst_in = '0;
                  state_in = ST_MAC;
               end
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_MAC;
            end
         end
         ST_ERD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (i_ff == XW'(DIM - 1)) begin
               state_in = ST_IDLE;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_ERD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // pipeline: read issued -> data valid -> product registered
   logic pv2_ff;
   always_ff @(posedge clock) begin
      prod_ff <= 64'(c_rd) * 64'(x_rd);
      pv2_ff  <= pv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tol_ff <= gss_pkg::TOL_RESET;
         cap_ff <= gss_pkg::SWEEP_RESET;
         pv_ff <= 1'b0;
         sw_ff <= '0;
         worst_ff <= '0;
         met_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff <= pv2_ff;
         sw_ff <= sw_in;
         worst_ff <= worst_in;
         met_ff <= met_in;
         if (csr_we) begin
            if (csr_index == gss_pkg::CSR_TOLERANCE) tol_ff <= csr_wdata;
            else cap_ff <= csr_wdata[15:0];
         end
      end
      i_ff <= i_in; j_ff <= j_in; acc_ff <= acc_in; old_ff <= old_in;
   end

   assign rsp_valid     = (state_ff == ST_EMIT);
   assign rsp_index     = 3'(i_ff);
   assign rsp_solution  = x_rd;
   assign rsp_sweeps    = sw_ff;
   assign rsp_converged = met_ff;
   assign rsp_last      = (i_ff == XW'(DIM - 1));
endmodule

// ===== src/gss_checker.sv =====
// Port-level checks for the Gauss-Seidel solver; bound to the solver module.
// Depends on gauss_seidel_solver.
module gss_port_props (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last,
   input logic [15:0] rsp_sweeps
);
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a solve");
   a_no_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results back to back");
   a_sweeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sweeps != 16'd0) else $error("zero sweeps");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy) else $error("busy after last");
endmodule

bind gauss_seidel_solver gss_port_props u_gss_port_props (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_last(rsp_last), .rsp_sweeps(rsp_sweeps));
